[rtl/umpd_pkg.sv]
// ----------------------------------------------------------------------------
// umpd_pkg
// Shared constants, types and helpers of the USB-MIDI event packet decoder.
// ----------------------------------------------------------------------------
package umpd_pkg;

	localparam int SYSEX_MAX  = 256;
	localparam int LANES      = 4;
	localparam int SYSEX_ROWS = (SYSEX_MAX + LANES - 1) / LANES;
	localparam int ROW_W      = (SYSEX_ROWS > 1) ? $clog2(SYSEX_ROWS) : 1;
	localparam int COUNT_W    = $clog2(SYSEX_MAX + 1);

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;
	typedef logic [2:0]  bcount_t;
	typedef logic [1:0]  len_t;
	typedef logic [3:0]  cin_t;

	// code index values
	localparam cin_t CIN_MISC        = 4'h0;
	localparam cin_t CIN_CABLE       = 4'h1;
	localparam cin_t CIN_SYS2        = 4'h2;
	localparam cin_t CIN_SYS3        = 4'h3;
	localparam cin_t CIN_SYSEX_START = 4'h4;
	localparam cin_t CIN_SYSEX_END1  = 4'h5;
	localparam cin_t CIN_SYSEX_END2  = 4'h6;
	localparam cin_t CIN_SYSEX_END3  = 4'h7;
	localparam cin_t CIN_NOTE_OFF    = 4'h8;
	localparam cin_t CIN_SINGLE_BYTE = 4'hF;

	localparam byte_t STATUS_NOTE_ON = 8'h90;
	localparam byte_t NOTE_ON_TO_OFF = 8'h10;
	localparam byte_t STATUS_SYSTEM  = 8'hF0;
	localparam byte_t STATUS_MTC     = 8'hF1;
	localparam byte_t STATUS_SPP     = 8'hF2;
	localparam byte_t STATUS_SONG    = 8'hF3;
	localparam byte_t STATUS_PROGRAM = 8'hC0;
	localparam byte_t STATUS_CHANNEL = 8'hE0;
	localparam byte_t STATUS_FIRST   = 8'h80;

	function automatic len_t status_length(input byte_t status);
		len_t len;
		if (status < STATUS_FIRST) len = 2'd0;
		else if (status < STATUS_PROGRAM) len = 2'd3;
		else if (status < STATUS_CHANNEL) len = 2'd2;
		else if (status < STATUS_SYSTEM) len = 2'd3;
		else if (status == STATUS_SPP) len = 2'd3;
		else if (status == STATUS_MTC || status == STATUS_SONG) len = 2'd2;
		else len = 2'd1;
		return len;
	endfunction

	// zero every byte at or above count
	function automatic word_t mask_bytes(input word_t w, input bcount_t count);
		word_t r;
		r = w;
		for (int i = 0; i < LANES; i++) begin
			if (3'(i) >= count) r[8*i +: 8] = 8'h00;
		end
		return r;
	endfunction

endpackage

[rtl/umpd_if.sv]
// ----------------------------------------------------------------------------
// umpd_if
// Valid/ready channels for event packets in and decoded messages out.
// ----------------------------------------------------------------------------
interface umpd_pkt_if import umpd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t header;
	byte_t lead_byte;
	byte_t second_byte;
	byte_t third_byte;

	modport source (output valid, header, lead_byte, second_byte, third_byte,
		input ready);
	modport sink (input valid, header, lead_byte, second_byte, third_byte,
		output ready);
endinterface

interface umpd_msg_if import umpd_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    message_kind;
	word_t   payload;
	bcount_t byte_count;
	logic    last_of_message;

	modport source (output valid, message_kind, payload, byte_count, last_of_message,
		input ready);
	modport sink (input valid, message_kind, payload, byte_count, last_of_message,
		output ready);
endinterface

[rtl/umpd_ram.sv]
// ----------------------------------------------------------------------------
// umpd_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module umpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/usb_midi_packet_decoder_core.sv]
// ----------------------------------------------------------------------------
// usb_midi_packet_decoder_core
// Decodes USB-MIDI class event packets into short messages and SysEx chunks.
// ----------------------------------------------------------------------------
// A packet transfer is accepted whenever the block is not draining a SysEx and
// the output register is empty or being taken. Channel, system and single-byte
// packets give one short message in the output register the cycle after (none
// for a lead byte below 80h with code index 8h to Fh). SysEx bytes are kept in
// four byte-lane RAMs of SYSEX_MAX/4 rows; after a SysEx end packet the drain
// first waits on the registered RAM read, then the first 4-byte chunk is loaded
// into the output register and the rest follow one per cycle while the sink
// takes them; no packet is accepted until the last chunk has been loaded. The store
// needs no clearing after reset; an overflowed SysEx is dropped with no result.
// ----------------------------------------------------------------------------
module usb_midi_packet_decoder_core import umpd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	umpd_pkt_if.sink   pkt,
	umpd_msg_if.source msg
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 ovf_q;
	logic [COUNT_W-1:0]   total_q;
	logic [ROW_W-1:0]     row_q;
	logic                 rd_ok_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	word_t                out_payload_q;
	bcount_t              out_count_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 pkt_fire;
	logic                 out_fire;
	logic                 out_load;
	cin_t                 code;
	byte_t                pb [LANES];
	byte_t                sb0;
	len_t                 short_len;
	logic                 is_append;
	logic                 is_end;
	len_t                 app_n;
	logic [COUNT_W:0]     app_sum;
	logic                 append_ok;
	logic                 ovf_next;

	logic                 lane_we    [LANES];
	logic [ROW_W-1:0]     lane_waddr [LANES];
	byte_t                lane_wdata [LANES];
	byte_t                lane_rdata [LANES];
	logic [ROW_W-1:0]     rd_row;

	logic [COUNT_W-1:0]   remaining;
	bcount_t              chunk_n;
	logic                 chunk_last;
	logic                 chunk_take;
	word_t                chunk_word;

	assign out_free  = !out_valid_q || msg.ready;
	assign pkt.ready = (state_q == ST_IDLE) && out_free;
	assign pkt_fire  = pkt.valid && pkt.ready;
	assign out_fire  = out_valid_q && msg.ready;
	assign out_load  = (pkt_fire && short_len != 2'd0) || chunk_take;

	assign code  = pkt.header[3:0];
	assign pb[0] = pkt.lead_byte;
	assign pb[1] = pkt.second_byte;
	assign pb[2] = pkt.third_byte;
	assign pb[3] = 8'h00;

	// code index decode: short messages and SysEx appends
	always_comb begin
		sb0       = pkt.lead_byte;
		short_len = 2'd0;
		is_append = 1'b0;
		is_end    = 1'b0;
		app_n     = 2'd0;
		unique case (code) inside
			[CIN_NOTE_OFF:CIN_SINGLE_BYTE]: begin
				if (pkt.lead_byte[7:4] == STATUS_NOTE_ON[7:4] && pkt.third_byte == 8'h00) begin
					sb0       = pkt.lead_byte - NOTE_ON_TO_OFF;
					short_len = 2'd3;
				end else begin
					short_len = status_length(pkt.lead_byte);
				end
			end
			CIN_SYS2, CIN_SYS3: short_len = code[1:0];
			CIN_SYSEX_START: begin
				is_append = 1'b1;
				app_n     = 2'd3;
			end
			CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
				is_append = 1'b1;
				is_end    = 1'b1;
				app_n     = code[1:0];
			end
			default: short_len = 2'd0;
		endcase
	end

	assign app_sum   = {1'b0, count_q} + (COUNT_W+1)'(app_n);
	assign append_ok = is_append && !ovf_q && (app_sum <= (COUNT_W+1)'(SYSEX_MAX));
	assign ovf_next  = !append_ok;

	// lane writes for the appended bytes
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [1:0] off;
			off           = 2'(l) - count_q[1:0];
			lane_we[l]    = pkt_fire && append_ok && (off < app_n);
			lane_wdata[l] = pb[off];
			lane_waddr[l] = ROW_W'((count_q + COUNT_W'(off)) >> 2);
		end
	end

	// drain chunk
	assign remaining  = total_q - COUNT_W'({row_q, 2'b00});
	assign chunk_last = remaining <= COUNT_W'(LANES);
	assign chunk_n    = chunk_last ? bcount_t'(remaining) : bcount_t'(LANES);
	assign chunk_take = (state_q == ST_DRAIN) && rd_ok_q && out_free;
	assign chunk_word = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};
	assign rd_row     = chunk_take ? ROW_W'(row_q + 1'b1) : row_q;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		umpd_ram #(
			.WIDTH (8),
			.DEPTH (SYSEX_ROWS)
		) u_lane (
			.clk   (clk),
			.we    (lane_we[l]),
			.waddr (lane_waddr[l]),
			.wdata (lane_wdata[l]),
			.raddr (rd_row),
			.rdata (lane_rdata[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pkt_fire) begin
						if (short_len != 2'd0) begin
							out_kind_q    <= 1'b0;
							out_payload_q <= mask_bytes({8'h00, pkt.third_byte, pkt.second_byte, sb0},
								bcount_t'(short_len));
							out_count_q   <= bcount_t'(short_len);
							out_last_q    <= 1'b1;
						end
						if (is_end) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							if (!ovf_next) begin
								state_q <= ST_DRAIN;
								total_q <= COUNT_W'(app_sum);
								row_q   <= '0;
								rd_ok_q <= 1'b0;
							end
						end else if (is_append) begin
							if (append_ok) count_q <= COUNT_W'(app_sum);
							else ovf_q <= 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					rd_ok_q <= 1'b1;
					if (chunk_take) begin
						out_kind_q    <= 1'b1;
						out_payload_q <= mask_bytes(chunk_word, chunk_n);
						out_count_q   <= chunk_n;
						out_last_q    <= chunk_last;
						row_q         <= ROW_W'(row_q + 1'b1);
						if (chunk_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign msg.valid           = out_valid_q;
	assign msg.message_kind    = out_kind_q;
	assign msg.payload         = out_payload_q;
	assign msg.byte_count      = out_count_q;
	assign msg.last_of_message = out_last_q;

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (total_q != '0))
		else $error("drain with empty sysex");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(SYSEX_MAX))
		else $error("sysex count past store size");

	a_full_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q && !out_last_q) |-> (out_count_q == bcount_t'(LANES)))
		else $error("non-final sysex chunk not full");

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_kind_q) |-> (out_count_q != 3'd0 && out_count_q <= 3'd3
			&& out_last_q))
		else $error("bad short message");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(chunk_take && chunk_last) |=> (state_q == ST_IDLE))
		else $error("drain did not end on final chunk");

endmodule
